>>> hdl/heightmap_bilinear_height_query_top_macros.svh
// ------------------------------------------------------------------------
// height query assertion macros
// shared property forms for the port checker
// ------------------------------------------------------------------------
`ifndef HEIGHTMAP_BILINEAR_HEIGHT_QUERY_TOP_MACROS_SVH
`define HEIGHTMAP_BILINEAR_HEIGHT_QUERY_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define HBQ_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define HBQ_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> hdl/hbq_pkg.sv
// ------------------------------------------------------------------------
// hbq_pkg
// shared widths, register indexes and inter-module types
// ------------------------------------------------------------------------
package hbq_pkg;

    // fixed field widths
    localparam int POS_W     = 26;
    localparam int HGT_W     = 32;
    localparam int DIM_W     = 9;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;

    // operation codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // reset value of both dimensions
    localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

    // command to the shared multiply / shift / add unit
    typedef struct packed {
        logic                    mul_en;
        logic                    add_en;
        logic                    shift_en;
        logic signed [HGT_W-1:0] op_a;
        logic signed [POS_W-1:0] op_b;
        logic [HGT_W-1:0]        op_c;
    } t_mac_cmd;

    // finished item from the sequencer
    typedef struct packed {
        logic             valid;
        logic [HGT_W-1:0] height;
        logic             oor;
    } t_res;

endpackage

>>> hdl/hbq_mem.sv
// ------------------------------------------------------------------------
// hbq_mem
// single-port height store with registered read data
// ------------------------------------------------------------------------
module hbq_mem
    import hbq_pkg::*;
#(
    parameter int DEPTH  = 66049,
    parameter int ADDR_W = 17
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [HGT_W-1:0]  i_wdata,
    output logic [HGT_W-1:0]  o_rdata
);

    logic [HGT_W-1:0] r_mem [DEPTH];
    logic [HGT_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/hbq_mac.sv
// ------------------------------------------------------------------------
// hbq_mac
// shared multiplier with registered product, then shift and add
// ------------------------------------------------------------------------
module hbq_mac
    import hbq_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  t_mac_cmd         i_cmd,
    output logic [HGT_W-1:0] o_res
);

    localparam int PROD_W = HGT_W + POS_W;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] prod_shr;
    logic [HGT_W-1:0]         addend;
    logic [HGT_W-1:0]         r_res;

    // product stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= $signed(i_cmd.op_a) * $signed(i_cmd.op_b);
        end
    end

    // floor shift of the product, wrapped to 32 bits
    assign prod_shr = r_prod >>> FRAC_BITS;
    assign addend   = i_cmd.shift_en ? prod_shr[HGT_W-1:0] : r_prod[HGT_W-1:0];

    // add stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_en) begin
            r_res <= i_cmd.op_c + addend;
        end
    end

    assign o_res = r_res;

endmodule

>>> hdl/hbq_seq.sv
// ------------------------------------------------------------------------
// hbq_seq
// item sequencer: range check, address, write or corner reads, three lerps
// ------------------------------------------------------------------------
module hbq_seq
    import hbq_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int ADDR_W    = 17
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_func,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [HGT_W-1:0] i_new_height,
    input  logic [DIM_W-1:0]        i_width_eff,
    input  logic [DIM_W-1:0]        i_height_eff,
    output t_mac_cmd                o_mac_cmd,
    input  logic [HGT_W-1:0]        i_mac_res,
    output logic                    o_mem_we,
    output logic [ADDR_W-1:0]       o_mem_addr,
    output logic [HGT_W-1:0]        o_mem_wdata,
    input  logic [HGT_W-1:0]        i_mem_rdata,
    output t_res                    o_res,
    input  logic                    i_res_take
);

    localparam int IW = POS_W - FRAC_BITS;
    localparam int CW = POS_W + 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_BMUL = 4'd1;
    localparam logic [3:0] S_BADD = 4'd2;
    localparam logic [3:0] S_WR   = 4'd3;
    localparam logic [3:0] S_RD0  = 4'd4;
    localparam logic [3:0] S_RD1  = 4'd5;
    localparam logic [3:0] S_RD2  = 4'd6;
    localparam logic [3:0] S_RD3  = 4'd7;
    localparam logic [3:0] S_L1M  = 4'd8;
    localparam logic [3:0] S_L1A  = 4'd9;
    localparam logic [3:0] S_L2M  = 4'd10;
    localparam logic [3:0] S_L2A  = 4'd11;
    localparam logic [3:0] S_L3M  = 4'd12;
    localparam logic [3:0] S_L3A  = 4'd13;
    localparam logic [3:0] S_DONE = 4'd14;

    logic [3:0]              r_state;
    logic [3:0]              n_state;
    logic                    accept;
    logic signed [IW-1:0]    ix_in;
    logic signed [IW-1:0]    iy_in;
    logic signed [CW-1:0]    ix_c;
    logic signed [CW-1:0]    iy_c;
    logic signed [CW-1:0]    w_c;
    logic signed [CW-1:0]    h_c;
    logic                    oor_in;
    logic                    r_func;
    logic                    r_oor;
    logic signed [IW-1:0]    r_ix;
    logic signed [IW-1:0]    r_iy;
    logic [FRAC_BITS-1:0]    r_fx;
    logic [FRAC_BITS-1:0]    r_fy;
    logic [HGT_W-1:0]        r_hgt;
    logic [HGT_W-1:0]        r_ha;
    logic [HGT_W-1:0]        r_hb;
    logic [HGT_W-1:0]        r_hc;
    logic [HGT_W-1:0]        r_hd;
    logic [HGT_W-1:0]        r_he;
    logic [ADDR_W-1:0]       base;
    logic [ADDR_W-1:0]       w_a;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    // integer parts and bounds in a common signed width
    assign ix_in = i_pos_x[POS_W-1:FRAC_BITS];
    assign iy_in = i_pos_y[POS_W-1:FRAC_BITS];
    assign ix_c  = CW'(ix_in);
    assign iy_c  = CW'(iy_in);
    assign w_c   = $signed({{(CW-DIM_W){1'b0}}, i_width_eff});
    assign h_c   = $signed({{(CW-DIM_W){1'b0}}, i_height_eff});

    // queries need the far corner inside, writes only the point itself
    always_comb begin
        if (i_func == FUNC_QUERY) begin
            oor_in = (ix_c < 0) || (iy_c < 0) || (ix_c >= w_c) || (iy_c >= h_c);
        end else begin
            oor_in = (ix_c < 0) || (iy_c < 0) || (ix_c > w_c) || (iy_c > h_c);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = oor_in ? S_DONE : S_BMUL;
                end
            end
            S_BMUL: n_state = S_BADD;
            S_BADD: n_state = (r_func == FUNC_QUERY) ? S_RD0 : S_WR;
            S_WR:   n_state = S_DONE;
            S_RD0:  n_state = S_RD1;
            S_RD1:  n_state = S_RD2;
            S_RD2:  n_state = S_RD3;
            S_RD3:  n_state = S_L1M;
            S_L1M:  n_state = S_L1A;
            S_L1A:  n_state = S_L2M;
            S_L2M:  n_state = S_L2A;
            S_L2A:  n_state = S_L3M;
            S_L3M:  n_state = S_L3A;
            S_L3A:  n_state = S_DONE;
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_func;
            r_oor  <= oor_in;
            r_ix   <= ix_in;
            r_iy   <= iy_in;
            r_fx   <= i_pos_x[FRAC_BITS-1:0];
            r_fy   <= i_pos_y[FRAC_BITS-1:0];
            r_hgt  <= i_new_height;
        end
    end

    // corner capture, one read behind the address
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_RD1: r_ha <= i_mem_rdata;
            S_RD2: r_hb <= i_mem_rdata;
            S_RD3: r_hc <= i_mem_rdata;
            S_L1M: r_hd <= i_mem_rdata;
            S_L2M: r_he <= i_mac_res;
            default: begin
            end
        endcase
    end

    // memory address: base from the shared unit plus a corner offset
    assign base = i_mac_res[ADDR_W-1:0];
    assign w_a  = ADDR_W'(i_width_eff);

    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_wdata = r_hgt;
        case (r_state)
            S_WR: begin
                o_mem_we   = 1'b1;
                o_mem_addr = base;
            end
            S_RD1:   o_mem_addr = base + w_a + ADDR_W'(1);
            S_RD2:   o_mem_addr = base + ADDR_W'(1);
            S_RD3:   o_mem_addr = base + w_a + ADDR_W'(2);
            default: o_mem_addr = base;
        endcase
    end

    // shared unit commands
    always_comb begin
        o_mac_cmd = '0;
        case (r_state)
            S_BMUL: begin
                o_mac_cmd.mul_en = 1'b1;
                o_mac_cmd.op_a   = $signed(HGT_W'(i_width_eff) + HGT_W'(1));
                o_mac_cmd.op_b   = POS_W'(r_iy);
            end
            S_BADD: begin
                o_mac_cmd.add_en = 1'b1;
                o_mac_cmd.op_c   = HGT_W'(r_ix);
            end
            S_L1M: begin
                o_mac_cmd.mul_en = 1'b1;
                o_mac_cmd.op_a   = $signed(r_hb - r_ha);
                o_mac_cmd.op_b   = $signed(POS_W'(r_fy));
            end
            S_L1A: begin
                o_mac_cmd.add_en   = 1'b1;
                o_mac_cmd.shift_en = 1'b1;
                o_mac_cmd.op_c     = r_ha;
            end
            S_L2M: begin
                o_mac_cmd.mul_en = 1'b1;
                o_mac_cmd.op_a   = $signed(r_hd - r_hc);
                o_mac_cmd.op_b   = $signed(POS_W'(r_fy));
            end
            S_L2A: begin
                o_mac_cmd.add_en   = 1'b1;
                o_mac_cmd.shift_en = 1'b1;
                o_mac_cmd.op_c     = r_hc;
            end
            S_L3M: begin
                o_mac_cmd.mul_en = 1'b1;
                o_mac_cmd.op_a   = $signed(i_mac_res - r_he);
                o_mac_cmd.op_b   = $signed(POS_W'(r_fx));
            end
            S_L3A: begin
                o_mac_cmd.add_en   = 1'b1;
                o_mac_cmd.shift_en = 1'b1;
                o_mac_cmd.op_c     = r_he;
            end
            default: begin
            end
        endcase
    end

    // finished item: height only for an in-range query
    always_comb begin
        o_res.valid  = (r_state == S_DONE);
        o_res.oor    = r_oor;
        o_res.height = ((r_func == FUNC_QUERY) && !r_oor) ? i_mac_res : '0;
    end

endmodule

>>> hdl/heightmap_bilinear_height_query_top.sv
// ------------------------------------------------------------------------
// heightmap_bilinear_height_query_top: bilinear height map with query
// query: base address, 4 corner reads on one port, three lerps; one item at a time
// write: base address, then the store write; out-of-range item skips to the result
// sync active-low reset clears control and dims to 256; store not cleared
// ------------------------------------------------------------------------
module heightmap_bilinear_height_query_top
    import hbq_pkg::*;
#(
    parameter int MAX_SIDE  = 256,
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_func,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [HGT_W-1:0] i_new_height,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [HGT_W-1:0] o_height_out,
    output logic                    o_out_of_range,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [DIM_W-1:0]        i_cfg_data
);

    localparam int DEPTH  = (MAX_SIDE + 1) * (MAX_SIDE + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    logic [DIM_W-1:0]  r_map_width;
    logic [DIM_W-1:0]  r_map_height;
    logic [DIM_W-1:0]  width_eff;
    logic [DIM_W-1:0]  height_eff;
    t_mac_cmd          mac_cmd;
    logic [HGT_W-1:0]  mac_res;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [HGT_W-1:0]  mem_wdata;
    logic [HGT_W-1:0]  mem_rdata;
    t_res              res;
    logic              res_take;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [HGT_W-1:0]  r_height;
    logic              r_oor;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= DIM_RESET;
            r_map_height <= DIM_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_MAP_WIDTH:  r_map_width  <= i_cfg_data;
                REG_MAP_HEIGHT: r_map_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // dimensions saturate at the grid side
    assign width_eff  = (32'(r_map_width) > 32'(MAX_SIDE)) ? DIM_W'(MAX_SIDE) : r_map_width;
    assign height_eff = (32'(r_map_height) > 32'(MAX_SIDE)) ? DIM_W'(MAX_SIDE) : r_map_height;

    hbq_seq #(
        .FRAC_BITS (FRAC_BITS),
        .ADDR_W    (ADDR_W)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_new_height (i_new_height),
        .i_width_eff  (width_eff),
        .i_height_eff (height_eff),
        .o_mac_cmd    (mac_cmd),
        .i_mac_res    (mac_res),
        .o_mem_we     (mem_we),
        .o_mem_addr   (mem_addr),
        .o_mem_wdata  (mem_wdata),
        .i_mem_rdata  (mem_rdata),
        .o_res        (res),
        .i_res_take   (res_take)
    );

    hbq_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk (i_clk),
        .i_cmd (mac_cmd),
        .o_res (mac_res)
    );

    hbq_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // output register, loads when empty or being drained
    assign res_take = !r_out_valid || !i_out_stall;

    always_comb begin
        n_out_valid = r_out_valid;
        if (res_take) begin
            n_out_valid = res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && res.valid) begin
            r_height <= res.height;
            r_oor    <= res.oor;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_height_out   = r_height;
    assign o_out_of_range = r_oor;

endmodule

>>> hdl/hbq_chk.sv
// ------------------------------------------------------------------------
// hbq_chk
// port-level checks on the height query block
// ------------------------------------------------------------------------
`include "heightmap_bilinear_height_query_top_macros.svh"

module hbq_chk
    import hbq_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic signed [HGT_W-1:0] o_height_out,
    input logic                    o_out_of_range
);

    // an out-of-range item never carries a height
    `HBQ_ASSERT_NOW(a_oor_zero, i_clk, i_rst_n, o_out_valid && o_out_of_range, o_height_out == '0, "out-of-range item with nonzero height")

    // one item at a time: busy right after an accept
    `HBQ_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input taken again right after an accept")

    // a stalled result stays put
    `HBQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_height_out) && $stable(o_out_of_range), "stalled result changed")

endmodule

bind heightmap_bilinear_height_query_top hbq_chk u_chk (.*);
